@@ hw/rtl/multi_policy_job_scheduler_core_defines.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef MULTI_POLICY_JOB_SCHEDULER_CORE_DEFINES_SVH
`define MULTI_POLICY_JOB_SCHEDULER_CORE_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define MPJS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("scheduler check failed");

// Checks a property on every clock edge, reset included.
`define MPJS_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("scheduler check failed");

`endif

@@ hw/rtl/mpjs_pkg.sv @@
// Types and constants of the multi-policy job scheduler.
`default_nettype none
package mpjs_pkg;
   localparam int QUEUE_DEPTH = 128;
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W = 15;
   localparam int TIME_W = 16;
   localparam int PRIO_W = 8;
   localparam int QUANT_W = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 8;
   localparam int ENTRY_W = ID_W + TIME_W + PRIO_W;

   localparam logic [CSR_IDX_W-1:0] REG_POLICY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_QUANTUM = 1'b1;

   localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd10;
   localparam logic [TIME_W-1:0] TIME_RESET = 16'd100;
   localparam logic [PRIO_W-1:0] PRIO_IDLE = 8'd100;

   typedef enum logic [1:0] {
      POL_FCFS = 2'd0,
      POL_SRTF = 2'd1,
      POL_RR   = 2'd2,
      POL_PRIO = 2'd3
   } policy_type;

   typedef enum logic [1:0] {
      KEY_HEAD,
      KEY_TIME,
      KEY_PRIO
   } key_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NEXT,
      ST_APP,
      ST_P_CHK,
      ST_P_RD,
      ST_P_CMP,
      ST_S_RD,
      ST_S_WR,
      ST_D_RD,
      ST_D_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] time_left;
      logic [PRIO_W-1:0] prio;
   } entry_type;
endpackage
`default_nettype wire

@@ hw/rtl/mpjs_req_if.sv @@
// Request channel of the scheduler.
`default_nettype none
interface mpjs_req_if;
   logic        valid;
   logic        ready;
   logic [14:0] requester_id;
   logic [15:0] remaining_time;
   logic [7:0]  priority_level;
   modport source(output valid, output requester_id, output remaining_time,
                  output priority_level, input ready);
   modport sink(input valid, input requester_id, input remaining_time,
                input priority_level, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mpjs_rsp_if.sv @@
// Result channel of the scheduler.
`default_nettype none
interface mpjs_rsp_if;
   logic        valid;
   logic        ready;
   logic        denied;
   logic [14:0] running_id;
   logic        running_valid;
   logic        queue_drop;
   modport source(output valid, output denied, output running_id,
                  output running_valid, output queue_drop, input ready);
   modport sink(input valid, input denied, input running_id,
                input running_valid, input queue_drop, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mpjs_csr_if.sv @@
// Configuration write channel of the scheduler.
`default_nettype none
interface mpjs_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] index;
   logic [7:0] data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mpjs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mpjs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ hw/rtl/multi_policy_job_scheduler_core.sv @@
// Top level of the multi-policy job scheduler.
//  channel   | role   | moves
//  req_chan  | sink   | request: requester id, remaining time, priority
//  rsp_chan  | source | result: denied, running id, running valid, drop
//  csr_chan  | sink   | register write: index, data
// A request scans the queue entry by entry for a duplicate or minimum, reading and then
// comparing each entry, and moves entries one by one when the queue closes up.
// The queue memory has one read port, so entries are read one after another.
// Reset is synchronous and needs no clearing pass; unwritten entries are never read.
// A new request is taken while the previous result still waits to be taken.
`default_nettype none
`include "multi_policy_job_scheduler_core_defines.svh"
module multi_policy_job_scheduler_core import mpjs_pkg::*; (
   input logic        clock,
   input logic        reset,
   mpjs_req_if.sink   req_chan,
   mpjs_rsp_if.source rsp_chan,
   mpjs_csr_if.sink   csr_chan
);
   state_type state_ff, state_in;
   policy_type policy_ff, policy_in;
   logic [QUANT_W-1:0] quantum_ff, quantum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ID_W-1:0] run_job_ff, run_job_in;
   logic run_flag_ff, run_flag_in;
   logic [TIME_W-1:0] run_time_ff, run_time_in;
   logic [PRIO_W-1:0] run_prio_ff, run_prio_in;
   logic [QUANT_W-1:0] slice_ff, slice_in;
   entry_type req_ff, req_in, app_ff, app_in, best_ff, best_in;
   key_type key_ff, key_in;
   logic app_first_ff, app_first_in, prom_ff, prom_in;
   logic dup_ff, dup_in, app_last_ff, app_last_in;
   logic denied_ff, denied_in, drop_ff, drop_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_denied_ff, rsp_denied_in;
   logic [ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic rsp_rv_ff, rsp_rv_in, rsp_drop_ff, rsp_drop_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;

   logic mem_we;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   entry_type mem_wdata, mem_rdata;
   logic [ENTRY_W-1:0] mem_rdata_raw;

   assign mem_rdata = entry_type'(mem_rdata_raw);

   mpjs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata_raw)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.denied = rsp_denied_ff;
   assign rsp_chan.running_id = rsp_id_ff;
   assign rsp_chan.running_valid = rsp_rv_ff;
   assign rsp_chan.queue_drop = rsp_drop_ff;

   always_comb begin
      entry_type rq, src, nb;
      logic better, take_it, less;
      logic [CNT_W-1:0] limit;
      logic [CNT_W-1:0] best_pos;
      state_in = state_ff;
      policy_in = policy_ff;
      quantum_in = quantum_ff;
      count_in = count_ff;
      run_job_in = run_job_ff;
      run_flag_in = run_flag_ff;
      run_time_in = run_time_ff;
      run_prio_in = run_prio_ff;
      slice_in = slice_ff;
      req_in = req_ff;
      app_in = app_ff;
      best_in = best_ff;
      key_in = key_ff;
      app_first_in = app_first_ff;
      prom_in = prom_ff;
      dup_in = dup_ff;
      app_last_in = app_last_ff;
      denied_in = denied_ff;
      drop_in = drop_ff;
      scan_in = scan_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_denied_in = rsp_denied_ff;
      rsp_id_in = rsp_id_ff;
      rsp_rv_in = rsp_rv_ff;
      rsp_drop_in = rsp_drop_ff;
      mem_we = 1'b0;
      mem_waddr = count_ff[IDX_W-1:0];
      mem_wdata = req_ff;
      mem_raddr = scan_ff[IDX_W-1:0];
      rq = '{id: req_chan.requester_id, time_left: req_chan.remaining_time,
             prio: req_chan.priority_level};
      src = app_first_ff ? app_ff : req_ff;
      better = 1'b0;
      take_it = 1'b0;
      less = 1'b0;
      nb = best_ff;
      best_pos = '0;
      limit = (key_ff == KEY_HEAD) ? CNT_W'(1) : count_ff;

      if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_POLICY: policy_in = policy_type'(csr_chan.data[1:0]);
            REG_QUANTUM: quantum_in = csr_chan.data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               req_in = rq;
               app_in = '{id: run_job_ff, time_left: run_time_ff, prio: run_prio_ff};
               app_first_in = 1'b0;
               prom_in = 1'b0;
               dup_in = 1'b0;
               app_last_in = 1'b0;
               drop_in = 1'b0;
               denied_in = 1'b0;
               key_in = KEY_HEAD;
               state_in = ST_NEXT;
               case (policy_ff)
                  POL_FCFS: begin
                     if (!run_flag_ff) begin
                        run_job_in = rq.id;
                        run_time_in = rq.time_left;
                        run_prio_in = rq.prio;
                        run_flag_in = 1'b1;
                     end
                     if (run_job_in == rq.id) begin
                        prom_in = (rq.time_left == '0);
                     end else begin
                        dup_in = 1'b1;
                        app_last_in = 1'b1;
                        denied_in = 1'b1;
                     end
                  end
                  POL_RR: begin
                     if (rq.time_left == '0) begin
                        prom_in = 1'b1;
                        slice_in = '0;
                     end else begin
                        if (!run_flag_ff) begin
                           run_job_in = rq.id;
                           run_time_in = rq.time_left;
                           run_prio_in = rq.prio;
                           run_flag_in = 1'b1;
                        end
                        if (run_job_in == rq.id) begin
                           if (slice_ff >= quantum_ff) begin
                              prom_in = 1'b1;
                              app_last_in = (count_ff != '0);
                              slice_in = '0;
                              denied_in = 1'b1;
                           end else begin
                              slice_in = slice_ff + QUANT_W'(1);
                           end
                        end else begin
                           dup_in = 1'b1;
                           app_last_in = 1'b1;
                           denied_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                     key_in = (policy_ff == POL_SRTF) ? KEY_TIME : KEY_PRIO;
                     if (!run_flag_ff) begin
                        better = 1'b1;
                     end else if (policy_ff == POL_SRTF) begin
                        better = rq.time_left < run_time_ff;
                     end else begin
                        better = rq.prio < run_prio_ff;
                     end
                     if (better) begin
                        app_first_in = run_flag_ff && (run_job_ff != rq.id);
                        run_job_in = rq.id;
                        run_time_in = rq.time_left;
                        run_prio_in = rq.prio;
                        run_flag_in = 1'b1;
                     end
                     if (run_job_in == rq.id) begin
                        if (rq.time_left == '0) begin
                           prom_in = 1'b1;
                        end else if (run_time_in != '0) begin
                           run_time_in = run_time_in - TIME_W'(1);
                        end
                     end else begin
                        dup_in = 1'b1;
                        app_last_in = 1'b1;
                        denied_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_NEXT: begin
            scan_in = '0;
            if (app_first_ff) begin
               state_in = ST_APP;
            end else if (prom_ff) begin
               state_in = ST_P_CHK;
            end else if (dup_ff) begin
               if (count_ff == '0) begin
                  dup_in = 1'b0;
               end else begin
                  state_in = ST_D_RD;
               end
            end else if (app_last_ff) begin
               state_in = ST_APP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_APP: begin
            if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
               mem_we = 1'b1;
               mem_wdata = src;
               count_in = count_ff + CNT_W'(1);
            end else begin
               drop_in = 1'b1;
            end
            if (app_first_ff) begin
               app_first_in = 1'b0;
            end else begin
               app_last_in = 1'b0;
            end
            state_in = ST_NEXT;
         end
         ST_P_CHK: begin
            if (count_ff == '0) begin
               run_flag_in = 1'b0;
               run_job_in = '0;
               run_time_in = '0;
               run_prio_in = PRIO_IDLE;
               prom_in = 1'b0;
               state_in = ST_NEXT;
            end else begin
               state_in = ST_P_RD;
            end
         end
         ST_P_RD: begin
            state_in = ST_P_CMP;
         end
         ST_P_CMP: begin
            case (key_ff)
               KEY_TIME: less = mem_rdata.time_left < best_ff.time_left;
               KEY_PRIO: less = mem_rdata.prio < best_ff.prio;
               default: less = 1'b0;
            endcase
            take_it = (scan_ff == '0) || less;
            nb = take_it ? mem_rdata : best_ff;
            best_in = nb;
            if (scan_ff + CNT_W'(1) < limit) begin
               scan_in = scan_ff + CNT_W'(1);
               state_in = ST_P_RD;
            end else begin
               run_job_in = nb.id;
               run_time_in = nb.time_left;
               run_prio_in = nb.prio;
               run_flag_in = 1'b1;
               best_pos = take_it ? scan_ff : CNT_W'(best_idx_ff);
               scan_in = best_pos;
               if (best_pos + CNT_W'(1) < count_ff) begin
                  state_in = ST_S_RD;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  prom_in = 1'b0;
                  state_in = ST_NEXT;
               end
            end
         end
         ST_S_RD: begin
            mem_raddr = IDX_W'(scan_ff + CNT_W'(1));
            state_in = ST_S_WR;
         end
         ST_S_WR: begin
            mem_we = 1'b1;
            mem_waddr = scan_ff[IDX_W-1:0];
            mem_wdata = mem_rdata;
            scan_in = scan_ff + CNT_W'(1);
            if (scan_ff + CNT_W'(2) < count_ff) begin
               state_in = ST_S_RD;
            end else begin
               count_in = count_ff - CNT_W'(1);
               prom_in = 1'b0;
               state_in = ST_NEXT;
            end
         end
         ST_D_RD: begin
            state_in = ST_D_CMP;
         end
         ST_D_CMP: begin
            if (mem_rdata.id == req_ff.id) begin
               dup_in = 1'b0;
               app_last_in = 1'b0;
               state_in = ST_NEXT;
            end else if (scan_ff + CNT_W'(1) < count_ff) begin
               scan_in = scan_ff + CNT_W'(1);
               state_in = ST_D_RD;
            end else begin
               dup_in = 1'b0;
               state_in = ST_NEXT;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_denied_in = denied_ff;
               rsp_id_in = run_flag_ff ? run_job_ff : '0;
               rsp_rv_in = run_flag_ff;
               rsp_drop_in = drop_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      best_idx_in = best_idx_ff;
      if (state_ff == ST_P_CMP) begin
         case (key_ff)
            KEY_TIME: begin
               if ((scan_ff == '0) || (mem_rdata.time_left < best_ff.time_left)) begin
                  best_idx_in = scan_ff[IDX_W-1:0];
               end
            end
            KEY_PRIO: begin
               if ((scan_ff == '0) || (mem_rdata.prio < best_ff.prio)) begin
                  best_idx_in = scan_ff[IDX_W-1:0];
               end
            end
            default: begin
               if (scan_ff == '0) begin
                  best_idx_in = scan_ff[IDX_W-1:0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         policy_ff <= POL_FCFS;
         quantum_ff <= QUANTUM_RESET;
         count_ff <= '0;
         run_job_ff <= '0;
         run_flag_ff <= 1'b0;
         run_time_ff <= TIME_RESET;
         run_prio_ff <= PRIO_IDLE;
         slice_ff <= '0;
         app_first_ff <= 1'b0;
         prom_ff <= 1'b0;
         dup_ff <= 1'b0;
         app_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         policy_ff <= policy_in;
         quantum_ff <= quantum_in;
         count_ff <= count_in;
         run_job_ff <= run_job_in;
         run_flag_ff <= run_flag_in;
         run_time_ff <= run_time_in;
         run_prio_ff <= run_prio_in;
         slice_ff <= slice_in;
         app_first_ff <= app_first_in;
         prom_ff <= prom_in;
         dup_ff <= dup_in;
         app_last_ff <= app_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      app_ff <= app_in;
      best_ff <= best_in;
      best_idx_ff <= best_idx_in;
      key_ff <= key_in;
      denied_ff <= denied_in;
      drop_ff <= drop_in;
      scan_ff <= scan_in;
      rsp_denied_ff <= rsp_denied_in;
      rsp_id_ff <= rsp_id_in;
      rsp_rv_ff <= rsp_rv_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   `MPJS_ASSERT(a_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH))
   `MPJS_ASSERT(a_idle_plan_clear,
      (state_ff == ST_IDLE) |-> !(app_first_ff || prom_ff || dup_ff || app_last_ff))
   `MPJS_ASSERT(a_accept_leaves_idle,
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_NEXT))
   `MPJS_ASSERT(a_result_from_done,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
   `MPJS_ASSERT(a_idle_id_zero, (rsp_valid_ff && !rsp_rv_ff) |-> (rsp_id_ff == '0))
endmodule
`default_nettype wire

@@ sim/mpjs_sched_checker.sv @@
`timescale 1ns / 100ps
// Scheduler checker: watches all three channels, predicts each result and compares it.
module mpjs_sched_checker import mpjs_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   mpjs_req_if   req,
   mpjs_rsp_if   rsp,
   mpjs_csr_if   csr,
   output int    mismatches,
   output int    outstanding,
   output int    checked
);
   typedef struct packed {
      logic              denied;
      logic [ID_W-1:0]   running_id;
      logic              running_valid;
      logic              queue_drop;
   } sched_result_type;

   logic [ID_W-1:0]    wait_id [QUEUE_DEPTH];
   logic [TIME_W-1:0]  wait_time [QUEUE_DEPTH];
   logic [PRIO_W-1:0]  wait_prio [QUEUE_DEPTH];
   int                 wait_count;
   logic [ID_W-1:0]    run_id;
   logic               run_flag;
   logic [TIME_W-1:0]  run_time;
   logic [PRIO_W-1:0]  run_prio;
   logic [QUANT_W-1:0] slices;
   policy_type         cur_policy;
   logic [QUANT_W-1:0] cur_quantum;
   logic               dropped;
   sched_result_type   expected_results[$];

   function automatic bit is_waiting(logic [ID_W-1:0] id);
      for (int k = 0; k < wait_count; k++) begin
         if (wait_id[k] == id) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void enqueue(logic [ID_W-1:0] id, logic [TIME_W-1:0] t,
                                   logic [PRIO_W-1:0] p);
      if (wait_count >= QUEUE_DEPTH) begin
         dropped = 1'b1;
         return;
      end
      wait_id[wait_count] = id;
      wait_time[wait_count] = t;
      wait_prio[wait_count] = p;
      wait_count++;
   endfunction

   function automatic void start_job(logic [ID_W-1:0] id, logic [TIME_W-1:0] t,
                                     logic [PRIO_W-1:0] p);
      run_id = id;
      run_time = t;
      run_prio = p;
      run_flag = 1'b1;
   endfunction

   function automatic void promote_next(key_type key);
      int best;
      best = 0;
      if (wait_count == 0) begin
         run_flag = 1'b0;
         run_id = '0;
         run_time = '0;
         run_prio = PRIO_IDLE;
         return;
      end
      for (int k = 1; k < wait_count; k++) begin
         if (key == KEY_TIME && wait_time[k] < wait_time[best]) best = k;
         if (key == KEY_PRIO && wait_prio[k] < wait_prio[best]) best = k;
      end
      start_job(wait_id[best], wait_time[best], wait_prio[best]);
      for (int k = best; k + 1 < wait_count; k++) begin
         wait_id[k] = wait_id[k + 1];
         wait_time[k] = wait_time[k + 1];
         wait_prio[k] = wait_prio[k + 1];
      end
      wait_count--;
   endfunction

   function automatic sched_result_type schedule_request(logic [ID_W-1:0] id,
         logic [TIME_W-1:0] t, logic [PRIO_W-1:0] p);
      sched_result_type r;
      logic denied;
      logic better;
      key_type key;
      dropped = 1'b0;
      if (cur_policy == POL_FCFS) begin
         if (!run_flag) start_job(id, t, p);
         if (run_id == id) begin
            if (t == 0) promote_next(KEY_HEAD);
            denied = 1'b0;
         end else begin
            if (!is_waiting(id)) enqueue(id, t, p);
            denied = 1'b1;
         end
      end else if (cur_policy == POL_RR) begin
         if (t == 0) begin
            promote_next(KEY_HEAD);
            slices = '0;
            denied = 1'b0;
         end else begin
            if (!run_flag) start_job(id, t, p);
            if (run_id == id) begin
               if (slices >= cur_quantum) begin
                  if (wait_count == 0) begin
                     promote_next(KEY_HEAD);
                  end else begin
                     promote_next(KEY_HEAD);
                     enqueue(id, t, p);
                  end
                  slices = '0;
                  denied = 1'b1;
               end else begin
                  slices = slices + 1'b1;
                  denied = 1'b0;
               end
            end else begin
               if (!is_waiting(id)) enqueue(id, t, p);
               denied = 1'b1;
            end
         end
      end else begin
         key = (cur_policy == POL_SRTF) ? KEY_TIME : KEY_PRIO;
         if (!run_flag) better = 1'b1;
         else if (key == KEY_TIME) better = t < run_time;
         else better = p < run_prio;
         if (better) begin
            if (run_flag && run_id != id) enqueue(run_id, run_time, run_prio);
            start_job(id, t, p);
         end
         if (run_id == id) begin
            if (t == 0) promote_next(key);
            else if (run_time > 0) run_time = run_time - 1'b1;
            denied = 1'b0;
         end else begin
            if (!is_waiting(id)) enqueue(id, t, p);
            denied = 1'b1;
         end
      end
      r.denied = denied;
      r.running_id = run_flag ? run_id : '0;
      r.running_valid = run_flag;
      r.queue_drop = dropped;
      return r;
   endfunction

   always @(posedge clock) begin
      sched_result_type want;
      sched_result_type got;
      if (reset) begin
         wait_count = 0;
         run_id = '0;
         run_flag = 1'b0;
         run_time = TIME_RESET;
         run_prio = PRIO_IDLE;
         slices = '0;
         cur_policy = POL_FCFS;
         cur_quantum = QUANTUM_RESET;
         expected_results.delete();
         mismatches = 0;
         checked = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == REG_POLICY) cur_policy = policy_type'(csr.data[1:0]);
            else if (csr.index == REG_QUANTUM) cur_quantum = csr.data;
         end
         if (rsp.valid && rsp.ready) begin
            got.denied = rsp.denied;
            got.running_id = rsp.running_id;
            got.running_valid = rsp.running_valid;
            got.queue_drop = rsp.queue_drop;
            checked++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result %p with no request waiting.", got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch on result %0d: expected %p, got %p.", checked, want, got);
               end
            end
         end
         if (req.valid && req.ready)
            expected_results.push_back(schedule_request(req.requester_id,
               req.remaining_time, req.priority_level));
      end
      outstanding = expected_results.size();
   end
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top: drives requests and register writes and reports the verdict.
module tb_top import mpjs_pkg::*; ();
   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   checked;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   sent;

   mpjs_req_if req ();
   mpjs_rsp_if rsp ();
   mpjs_csr_if csr ();

   multi_policy_job_scheduler_core dut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp), .csr_chan(csr)
   );

   mpjs_sched_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr),
      .mismatches(mismatches), .outstanding(outstanding), .checked(checked)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (recv_stall_pct > 0) rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      else rsp.ready <= 1'b1;
   end

   task automatic send_request(logic [ID_W-1:0] id, logic [TIME_W-1:0] t,
                               logic [PRIO_W-1:0] p);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.requester_id <= id;
      req.remaining_time <= t;
      req.priority_level <= p;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent++;
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic set_mode(policy_type pol, logic [QUANT_W-1:0] q);
      req.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      write_register(REG_POLICY, CSR_DATA_W'(pol));
      write_register(REG_QUANTUM, q);
   endtask

   task automatic random_request(bit wide);
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] t;
      int                pick;
      pick = $urandom_range(99);
      if (wide) id = (pick < 85) ? ID_W'($urandom_range(1, 400)) : ID_W'($urandom);
      else if (pick < 80) id = ID_W'($urandom_range(0, 11));
      else if (pick < 92) id = ID_W'($urandom_range(12, 400));
      else id = ID_W'($urandom);
      pick = $urandom_range(99);
      if (!wide && pick < 22) t = '0;
      else if (pick < 30) t = '1;
      else if (pick < 80) t = TIME_W'($urandom_range(1, 300));
      else t = TIME_W'($urandom);
      send_request(id, t, PRIO_W'($urandom));
   endtask

   initial begin
      policy_type        phase_pol[8] = '{POL_FCFS, POL_FCFS, POL_SRTF, POL_RR,
                                          POL_RR, POL_PRIO, POL_RR, POL_SRTF};
      logic [QUANT_W-1:0] phase_q[8] = '{8'd10, 8'd1, 8'd255, 8'd0, 8'd1, 8'd200,
                                          8'd255, 8'd3};
      bit                phase_wide[8] = '{1, 0, 0, 0, 1, 0, 0, 1};
      sent = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.requester_id <= '0;
      req.remaining_time <= '0;
      req.priority_level <= '0;
      csr.valid <= 1'b0;
      csr.index <= '0;
      csr.data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(15'd5, 16'd10, 8'd3);
      send_request(15'd7, 16'd20, 8'd1);
      send_request(15'd7, 16'd20, 8'd1);
      send_request(15'h7fff, 16'hffff, 8'hff);
      send_request(15'd5, 16'd0, 8'd0);
      send_request(15'd7, 16'd0, 8'd0);
      send_request(15'h7fff, 16'd0, 8'd0);
      set_mode(POL_SRTF, 8'd10);
      send_request(15'd9, 16'd50, 8'd9);
      send_request(15'd3, 16'd4, 8'd9);
      send_request(15'd3, 16'd2, 8'd9);
      send_request(15'd3, 16'd0, 8'd9);
      send_request(15'd9, 16'd0, 8'd9);
      set_mode(POL_PRIO, 8'd10);
      send_request(15'd1, 16'd1, 8'd50);
      send_request(15'd2, 16'd8, 8'd0);
      send_request(15'd1, 16'd0, 8'd50);
      send_request(15'd2, 16'd0, 8'd0);
      set_mode(POL_RR, 8'd0);
      send_request(15'd4, 16'd6, 8'd1);
      send_request(15'd6, 16'd6, 8'd1);
      send_request(15'd4, 16'd6, 8'd1);
      send_request(15'd6, 16'd6, 8'd1);
      send_request(15'd6, 16'd0, 8'd1);
      send_request(15'd4, 16'd0, 8'd1);

      for (int ph = 0; ph < 8; ph++) begin
         set_mode(phase_pol[ph], phase_q[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         repeat (66) random_request(phase_wide[ph]);
      end
      req.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (600) @(posedge clock);

      $display("Sent %0d requests and checked %0d results under all four policies,",
               sent, checked);
      $display("with quantum settings from 0 to 255 and four idle and stall patterns.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end
endmodule
